// File: hdl/rssi_sm_pkg.sv
// ----------------------------------------------------------------------------
// rssi_sm_pkg: shared types and constants of the RSSI S-meter scaler
// Item and result structs, register indexes, the band correction table and
// the stage records of the pipeline modules.
// ----------------------------------------------------------------------------
package rssi_sm_pkg;

  localparam int REG_W = 8;

  typedef enum logic [0:0] {
    REG_S0_LEVEL = 1'b0,
    REG_S9_LEVEL = 1'b1
  } reg_idx_t;

  localparam logic [REG_W-1:0] S0_RESET = 8'd130;
  localparam logic [REG_W-1:0] S9_RESET = 8'd76;

  // floor(x / 9) == (x * RECIP_9) >> RECIP_SHIFT for every span * 100 up to 25500
  localparam logic [14:0] RECIP_9     = 15'd29128;
  localparam int          RECIP_SHIFT = 18;

  localparam logic [3:0] SU_MAX   = 4'd9;
  localparam logic [6:0] DB_MAX   = 7'd99;
  localparam logic [2:0] BARS_MAX = 3'd4;

  typedef struct packed {
    logic signed [8:0] sig_dbm;
    logic [2:0]        band;
  } item_t;

  typedef struct packed {
    logic signed [9:0] corrected_dbm;
    logic [3:0]        s_unit;
    logic [6:0]        over_s9_db;
    logic [2:0]        over_s9_bars;
    logic [3:0]        bar_level;
    logic              above_s9;
    logic              zero_span;
  } result_t;

  // after band correction and span product
  typedef struct packed {
    logic              valid;
    logic signed [9:0] corrected;
    logic [7:0]        s9;
    logic [8:0]        num_mag;
    logic              num_pos;
    logic              num_neg;
    logic              span_neg;
    logic [14:0]       span_x100;
  } st1_t;

  // divisor and scaled numerator ready
  typedef struct packed {
    logic              valid;
    logic signed [9:0] corrected;
    logic [6:0]        over_db;
    logic [15:0]       num_x100;
    logic [11:0]       den_mag;
    logic              num_pos;
    logic              q_pos;
  } st2_t;

  // quotient bit 3 and saturation known
  typedef struct packed {
    logic              valid;
    logic signed [9:0] corrected;
    logic [6:0]        over_db;
    logic [2:0]        bars;
    logic              zero;
    logic              num_pos;
    logic              q_pos;
    logic              sat;
    logic              q3;
    logic [15:0]       rem;
    logic [11:0]       den;
  } st3_t;

  // quotient bits 3..1 known
  typedef struct packed {
    logic              valid;
    logic signed [9:0] corrected;
    logic [6:0]        over_db;
    logic [2:0]        bars;
    logic              zero;
    logic              num_pos;
    logic              q_pos;
    logic              sat;
    logic [2:0]        q_hi;
    logic [15:0]       rem;
    logic [11:0]       den;
  } st4_t;

  function automatic logic signed [5:0] band_corr(input logic [2:0] band);
    logic signed [5:0] corr;
    case (band)
      3'd0:    corr = -6'sd15;
      3'd1:    corr = -6'sd25;
      3'd2:    corr = -6'sd20;
      3'd3:    corr = -6'sd4;
      3'd4:    corr = -6'sd7;
      3'd5:    corr = -6'sd6;
      3'd6:    corr = -6'sd1;
      default: corr = 6'sd0;
    endcase
    return corr;
  endfunction

endpackage

// File: hdl/rssi_s_meter_scaler.sv
// ----------------------------------------------------------------------------
// rssi_s_meter_scaler: band-corrected RSSI to S-meter units and bars
// Five-stage pipeline: correction, divisor, two divider stages, output.
// ----------------------------------------------------------------------------
// Takes one item per clock, every clock: busy is always low. Each item gives
// one result on the result port, marked by done, once it has passed the st1,
// st2, st3 and st4 stage registers and the output register. Results are not
// held, so the receiver must take done as it comes. Write s0_ref and s9_ref
// only while no item is in flight.
module rssi_s_meter_scaler (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  output logic                    busy,
  input  rssi_sm_pkg::item_t      item,
  output logic                    done,
  output rssi_sm_pkg::result_t    result,
  input  logic                    cfg_we,
  input  rssi_sm_pkg::reg_idx_t   cfg_addr,
  input  logic [7:0]              cfg_data
);
  import rssi_sm_pkg::*;

  logic [REG_W-1:0] s0_ref;
  logic [REG_W-1:0] s9_ref;
  st2_t             st2;
  st4_t             st4;
  logic             b0;
  logic [3:0]       q;
  logic [3:0]       su_div;
  logic [3:0]       s_unit;
  result_t          result_next;

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      s0_ref <= S0_RESET;
      s9_ref <= S9_RESET;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_S0_LEVEL: s0_ref <= cfg_data;
        REG_S9_LEVEL: s9_ref <= cfg_data;
        default: ;
      endcase
    end
  end

  rssi_sm_front u_front (
    .clk    (clk),
    .rst    (rst),
    .take   (start && !busy),
    .item   (item),
    .s0_ref (s0_ref),
    .s9_ref (s9_ref),
    .st2    (st2)
  );

  rssi_sm_div u_div (
    .clk (clk),
    .rst (rst),
    .st2 (st2),
    .st4 (st4)
  );

  always_comb begin
    b0 = st4.rem >= {4'b0, st4.den};
    q  = {st4.q_hi, b0};
    su_div = (st4.sat || (q > SU_MAX)) ? SU_MAX : q;
    // zero divisor: full scale for a positive numerator, else bottom
    if (st4.zero) begin
      s_unit = st4.num_pos ? SU_MAX : 4'd0;
    end else begin
      s_unit = st4.q_pos ? su_div : 4'd0;
    end

    result_next.corrected_dbm = st4.corrected;
    result_next.s_unit        = s_unit;
    result_next.over_s9_db    = st4.over_db;
    result_next.over_s9_bars  = st4.bars;
    result_next.bar_level     = s_unit + {1'b0, st4.bars};
    result_next.above_s9      = (st4.bars != 3'd0);
    result_next.zero_span     = st4.zero;
  end

  always_ff @(posedge clk) begin
    result <= result_next;
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= st4.valid;
    end
  end

endmodule

// File: hdl/rssi_sm_front.sv
// ----------------------------------------------------------------------------
// rssi_sm_front: band correction, span and numerator scaling
// Stage 1 applies the band correction, forms the numerator and S0 - S9;
// stage 2 makes the S-unit divisor, scales the numerator, clamps dB over S9.
// ----------------------------------------------------------------------------
module rssi_sm_front (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 take,
  input  rssi_sm_pkg::item_t   item,
  input  logic [7:0]           s0_ref,
  input  logic [7:0]           s9_ref,
  output rssi_sm_pkg::st2_t    st2
);
  import rssi_sm_pkg::*;

  st1_t              st1, st1_next;
  st2_t              st2_next;
  logic signed [5:0] corr;
  logic signed [9:0] corrected;
  logic signed [10:0] num;
  logic signed [8:0] span;
  logic [7:0]        span_mag;
  logic [29:0]       den_prod;
  logic signed [10:0] over_sum;

  always_comb begin
    corr      = band_corr(item.band);
    corrected = {item.sig_dbm[8], item.sig_dbm} + {{4{corr[5]}}, corr};
    num       = {corrected[9], corrected} + {3'b000, s0_ref};
    span      = {1'b0, s0_ref} - {1'b0, s9_ref};
    span_mag  = span[8] ? 8'(-span) : span[7:0];

    st1_next.valid     = take;
    st1_next.corrected = corrected;
    st1_next.s9        = s9_ref;
    st1_next.num_mag   = num[10] ? 9'(-num) : num[8:0];
    st1_next.num_pos   = !num[10] && (num != 11'sd0);
    st1_next.num_neg   = num[10];
    st1_next.span_neg  = span[8];
    st1_next.span_x100 = {1'b0, span_mag, 6'b0} + {2'b0, span_mag, 5'b0}
                       + {5'b0, span_mag, 2'b0};
  end

  always_comb begin
    den_prod = 30'(st1.span_x100) * 30'(RECIP_9);
    over_sum = {st1.corrected[9], st1.corrected} + {3'b000, st1.s9};

    st2_next.valid     = st1.valid;
    st2_next.corrected = st1.corrected;
    st2_next.num_x100  = {1'b0, st1.num_mag, 6'b0} + {2'b0, st1.num_mag, 5'b0}
                       + {5'b0, st1.num_mag, 2'b0};
    st2_next.den_mag   = den_prod[RECIP_SHIFT +: 12];
    st2_next.num_pos   = st1.num_pos;
    // quotient is positive only when numerator and divisor share a sign
    st2_next.q_pos     = (st1.num_pos && !st1.span_neg) || (st1.num_neg && st1.span_neg);
    if (over_sum[10]) begin
      st2_next.over_db = 7'd0;
    end else if (over_sum > 11'sd99) begin
      st2_next.over_db = DB_MAX;
    end else begin
      st2_next.over_db = over_sum[6:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st1.valid <= 1'b0;
      st2.valid <= 1'b0;
    end else begin
      st1 <= st1_next;
      st2 <= st2_next;
    end
  end

endmodule

// File: hdl/rssi_sm_div.sv
// ----------------------------------------------------------------------------
// rssi_sm_div: restoring divider stages for the S-unit quotient
// Stage 3 detects a quotient of 16 or more, resolves bit 3, sets the bars;
// stage 4 resolves bits 2 and 1. Bit 0 is left for the output stage.
// ----------------------------------------------------------------------------
module rssi_sm_div (
  input  logic               clk,
  input  logic               rst,
  input  rssi_sm_pkg::st2_t  st2,
  output rssi_sm_pkg::st4_t  st4
);
  import rssi_sm_pkg::*;

  st3_t        st3, st3_next;
  st4_t        st4_next;
  logic [15:0] den8;
  logic [15:0] den4;
  logic [15:0] den2;
  logic        b2;
  logic [15:0] rem2;
  logic        b1;

  always_comb begin
    den8 = {1'b0, st2.den_mag, 3'b0};

    st3_next.valid     = st2.valid;
    st3_next.corrected = st2.corrected;
    st3_next.over_db   = st2.over_db;
    st3_next.zero      = (st2.den_mag == 12'd0);
    st3_next.num_pos   = st2.num_pos;
    st3_next.q_pos     = st2.q_pos;
    st3_next.sat       = {1'b0, st2.num_x100} >= {1'b0, st2.den_mag, 4'b0};
    st3_next.q3        = st2.num_x100 >= den8;
    st3_next.rem       = st3_next.q3 ? (st2.num_x100 - den8) : st2.num_x100;
    st3_next.den       = st2.den_mag;
    if (st2.over_db >= 7'd40) begin
      st3_next.bars = BARS_MAX;
    end else if (st2.over_db >= 7'd30) begin
      st3_next.bars = 3'd3;
    end else if (st2.over_db >= 7'd20) begin
      st3_next.bars = 3'd2;
    end else if (st2.over_db >= 7'd10) begin
      st3_next.bars = 3'd1;
    end else begin
      st3_next.bars = 3'd0;
    end
  end

  always_comb begin
    den4 = {2'b0, st3.den, 2'b0};
    den2 = {3'b0, st3.den, 1'b0};
    b2   = st3.rem >= den4;
    rem2 = b2 ? (st3.rem - den4) : st3.rem;
    b1   = rem2 >= den2;

    st4_next.valid     = st3.valid;
    st4_next.corrected = st3.corrected;
    st4_next.over_db   = st3.over_db;
    st4_next.bars      = st3.bars;
    st4_next.zero      = st3.zero;
    st4_next.num_pos   = st3.num_pos;
    st4_next.q_pos     = st3.q_pos;
    st4_next.sat       = st3.sat;
    st4_next.q_hi      = {st3.q3, b2, b1};
    st4_next.rem       = b1 ? (rem2 - den2) : rem2;
    st4_next.den       = st3.den;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st3.valid <= 1'b0;
      st4.valid <= 1'b0;
    end else begin
      st3 <= st3_next;
      st4 <= st4_next;
    end
  end

endmodule

// File: hdl/rssi_sm_chk.sv
// ----------------------------------------------------------------------------
// rssi_sm_chk: port-level checks of the RSSI S-meter scaler
// Latency, result consistency and zero-span behavior, bound to the top.
// ----------------------------------------------------------------------------
module rssi_sm_chk (
  input logic                   clk,
  input logic                   rst,
  input logic                   start,
  input logic                   busy,
  input logic                   done,
  input rssi_sm_pkg::result_t   result
);
  import rssi_sm_pkg::*;

  // every result traces back to an item that passed the stage and output registers
  a_latency: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, 5))
    else $error("result without an item five cycles earlier");

  a_bar_sum: assert property (@(posedge clk) disable iff (rst)
    done |-> (result.bar_level == result.s_unit + {1'b0, result.over_s9_bars}))
    else $error("bar level is not s_unit plus over-S9 bars");

  a_plus: assert property (@(posedge clk) disable iff (rst)
    done |-> (result.above_s9 == (result.over_s9_bars != 3'd0)))
    else $error("above_s9 disagrees with over-S9 bars");

  a_zero_span: assert property (@(posedge clk) disable iff (rst)
    (done && result.zero_span) |-> (result.s_unit == 4'd0 || result.s_unit == SU_MAX))
    else $error("zero span gave an intermediate S-unit");

endmodule

bind rssi_s_meter_scaler rssi_sm_chk u_rssi_sm_chk (
  .clk    (clk),
  .rst    (rst),
  .start  (start),
  .busy   (busy),
  .done   (done),
  .result (result)
);
